// File: rtl/lhc_pkg.sv
package lhc_pkg;

    // Widths fixed by the request and result fields.
    localparam int KEY_W   = 32;
    localparam int CAP_W   = 7;
    localparam int COUNT_W = 32;

    // Capacity after reset, before it is limited to the built entry count.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Action applied to the store for one request.
    typedef struct packed {
        logic apply;  // a request is being retired this cycle
        logic hit;    // the key matched an occupied entry
        logic full;   // on a miss, the least recently used entry is replaced
    } lhc_op_t;

endpackage

// File: rtl/lhc_tag_store.sv
module lhc_tag_store
    import lhc_pkg::*;
#(
    parameter int N = 64
) (
    input  logic             aclk,
    input  logic [KEY_W-1:0] key,
    input  logic [N-1:0]     occ_mask,
    input  logic             wr_en,
    input  logic [N-1:0]     wr_onehot,
    output logic [N-1:0]     match
);

    logic [KEY_W-1:0] key_reg [N];

    // Every stored key has its own comparator; only occupied entries can match.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            match[i] = occ_mask[i] && (key_reg[i] == key);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (wr_en && wr_onehot[i]) begin
                key_reg[i] <= key;
            end
        end
    end

endmodule

// File: rtl/lhc_recency.sv
module lhc_recency
    import lhc_pkg::*;
#(
    parameter int N  = 64,
    parameter int RW = 6,
    parameter int CW = 7
) (
    input  logic          aclk,
    input  lhc_op_t       op,
    input  logic [N-1:0]  match,
    input  logic [N-1:0]  occ_mask,
    input  logic [CW-1:0] occ_count,
    output logic [N-1:0]  sel_onehot
);

    logic [RW-1:0] rank_reg [N];
    logic [RW-1:0] rank_hit;
    logic [CW-1:0] occ_less_one;
    logic [CW-1:0] limit;
    logic [N-1:0]  victim;
    logic [N-1:0]  insert_onehot;

    assign occ_less_one = occ_count - CW'(1);

    // Rank 0 is most recent; occupied entries hold 0 .. occ_count-1.
    always_comb begin
        rank_hit = '0;
        for (int i = 0; i < N; i++) begin
            if (match[i]) begin
                rank_hit = rank_hit | rank_reg[i];
            end
            victim[i]        = occ_mask[i] && (rank_reg[i] == RW'(occ_less_one));
            insert_onehot[i] = (occ_count == CW'(i));
        end
    end

    // Entries younger than the limit age by one place when the chosen entry
    // moves to the front. A new entry counts as older than everything.
    always_comb begin
        if (op.hit) begin
            sel_onehot = match;
            limit      = CW'(rank_hit);
        end else if (op.full) begin
            sel_onehot = victim;
            limit      = occ_less_one;
        end else begin
            sel_onehot = insert_onehot;
            limit      = occ_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.apply) begin
            for (int i = 0; i < N; i++) begin
                if (sel_onehot[i]) begin
                    rank_reg[i] <= '0;
                end else if (occ_mask[i] && (CW'(rank_reg[i]) < limit)) begin
                    rank_reg[i] <= rank_reg[i] + RW'(1);
                end
            end
        end
    end

endmodule

// File: rtl/lru_cache_hit_counter.sv
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// request   | s_valid s_ready s_request_key s_final_request | in
// result    | m_valid m_ready m_hit m_hit_count m_run_done  | out
// config    | cfg_we cfg_wdata (capacity)                  | in
//
// One request is taken every cycle while s_ready is high. A request waits in
// the input register while it is looked up; the tag compare and rank update
// are combinational. When it retires, it is applied to the store and its
// result is loaded into the result register. The store is written back in
// the same cycle that loads the result register, so back-to-back requests
// see each other's effect. When the result register is full and not taken,
// the input register holds and s_ready falls once it is also full. Reset
// clears the occupancy, the hit count and the handshake state and sets
// capacity to 64; there is no clearing pass. A final request clears the
// store as it retires.
module lru_cache_hit_counter
    import lhc_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [KEY_W-1:0] s_request_key,
    input  logic                    s_final_request,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic [COUNT_W-1:0]      m_hit_count,
    output logic                    m_run_done
);

    localparam int RW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;
    localparam int N_BITS = MAX_ENTRIES;

    logic [CAP_W-1:0]   cap_reg;
    logic               in_valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               final_reg;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [COUNT_W-1:0] hits_reg, hits_next;
    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [COUNT_W-1:0] m_hit_count_reg;
    logic               m_run_done_reg;

    logic               retire;
    logic [N_BITS-1:0]  occ_mask;
    logic [N_BITS-1:0]  match;
    logic [N_BITS-1:0]  sel_onehot;
    logic [XW-1:0]      eff_cap;
    logic               hit;
    lhc_op_t            op;

    // The input register moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign retire  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !m_valid_reg || m_ready;

    // Capacity zero acts as one; anything above the built size is clamped.
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = XW'(1);
        end else if (XW'(cap_reg) > XW'(MAX_ENTRIES)) begin
            eff_cap = XW'(MAX_ENTRIES);
        end else begin
            eff_cap = XW'(cap_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < N_BITS; i++) begin
            occ_mask[i] = (CW'(i) < occ_reg);
        end
    end

    assign hit      = |match;
    assign op.apply = retire;
    assign op.hit   = hit;
    assign op.full  = (XW'(occ_reg) >= eff_cap);

    lhc_tag_store #(
        .N (N_BITS)
    ) u_tags (
        .aclk      (aclk),
        .key       (key_reg),
        .occ_mask  (occ_mask),
        .wr_en     (retire && !hit),
        .wr_onehot (sel_onehot),
        .match     (match)
    );

    lhc_recency #(
        .N  (N_BITS),
        .RW (RW),
        .CW (CW)
    ) u_recency (
        .aclk       (aclk),
        .op         (op),
        .match      (match),
        .occ_mask   (occ_mask),
        .occ_count  (occ_reg),
        .sel_onehot (sel_onehot)
    );

    // The hit count saturates at all ones.
    always_comb begin
        hits_next = hits_reg;
        if (hit && (hits_reg != '1)) begin
            hits_next = hits_reg + COUNT_W'(1);
        end
        occ_next = occ_reg;
        if (!hit && !op.full) begin
            occ_next = occ_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            occ_reg      <= '0;
            hits_reg     <= '0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (retire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (retire) begin
                // A final request closes the run after its result is formed.
                if (final_reg) begin
                    occ_reg  <= '0;
                    hits_reg <= '0;
                end else begin
                    occ_reg  <= occ_next;
                    hits_reg <= hits_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            key_reg   <= $unsigned(s_request_key);
            final_reg <= s_final_request;
        end
        if (retire) begin
            m_hit_reg       <= hit;
            m_hit_count_reg <= hits_next;
            m_run_done_reg  <= final_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_hit_count = m_hit_count_reg;
    assign m_run_done  = m_run_done_reg;

endmodule
